/* design/tre_pkg.sv */
// Shared types, opcodes and helpers of the tiny RISC executor.
`timescale 1ns / 1ps
package tre_pkg;

    localparam int PC_W    = 12;
    localparam int LEN_W   = 13;
    localparam int XLEN    = 32;
    localparam int REG_N   = 8;
    localparam int RIDX_W  = 3;
    localparam int IMM_W   = 6;
    localparam int SADDR_W = 8;
    localparam int IW_W    = 16;

    typedef logic [3:0] opcode_t;

    localparam opcode_t OP_RTYPE = 4'd0;
    localparam opcode_t OP_JUMP  = 4'd2;
    localparam opcode_t OP_LW    = 4'd4;
    localparam opcode_t OP_SW    = 4'd5;
    localparam opcode_t OP_ADDI  = 4'd8;
    localparam opcode_t OP_BEQ   = 4'd9;

    typedef logic [2:0] funct_t;

    localparam funct_t FN_ADD = 3'd0;
    localparam funct_t FN_SUB = 3'd1;
    localparam funct_t FN_AND = 3'd2;
    localparam funct_t FN_OR  = 3'd3;

    // Register index on the configuration port (byte address bit 2)
    localparam logic REG_PROGRAM_LENGTH = 1'b0;

    typedef struct packed {
        logic [IW_W-1:0] instruction_word;
    } tre_in_t;

    typedef struct packed {
        logic [PC_W-1:0]        next_pc;
        logic                   halted;
        logic                   reg_written;
        logic [RIDX_W-1:0]      reg_number;
        logic signed [XLEN-1:0] reg_value;
        logic                   stored;
        logic [SADDR_W-1:0]     store_address;
        logic signed [XLEN-1:0] store_value;
        logic                   bad_address;
    } tre_out_t;

    // Clearing-pass status from the data memory to the register file
    typedef struct packed {
        logic              busy;
        logic [RIDX_W-1:0] rf_idx;
    } tre_clr_t;

    function automatic logic [XLEN-1:0] alu(input logic [XLEN-1:0] a,
                                            input logic [XLEN-1:0] b,
                                            input funct_t fn);
        logic [XLEN-1:0] r;
        case (fn)
            FN_ADD:  r = a + b;
            FN_SUB:  r = a - b;
            FN_AND:  r = a & b;
            FN_OR:   r = a | b;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* design/tre_stream_if.sv */
// Valid/ready stream channel carrying one payload struct per transfer.
`timescale 1ns / 1ps
interface tre_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/tre_regfile.sv */
// Eight-entry register file: one write port, two registered read ports.
`timescale 1ns / 1ps
module tre_regfile
    import tre_pkg::*;
(
    input  logic              clk,
    input  tre_clr_t          clr,
    input  logic              re,
    input  logic [RIDX_W-1:0] raddr_a,
    input  logic [RIDX_W-1:0] raddr_b,
    output logic [XLEN-1:0]   rdata_a,
    output logic [XLEN-1:0]   rdata_b,
    input  logic              we,
    input  logic [RIDX_W-1:0] waddr,
    input  logic [XLEN-1:0]   wdata
);

    logic [XLEN-1:0] mem [REG_N];

    always_ff @(posedge clk)
    begin
        if (clr.busy)
        begin
            mem[clr.rf_idx] <= '0;
        end
        else if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* design/tre_dmem.sv */
// Data memory with registered read and a clearing pass after reset.
`timescale 1ns / 1ps
module tre_dmem
    import tre_pkg::*;
#(
    parameter int DATA_WORDS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output tre_clr_t                      clr,
    input  logic                          re,
    input  logic                          we,
    input  logic [$clog2(DATA_WORDS)-1:0] addr,
    input  logic [XLEN-1:0]               wdata,
    output logic [XLEN-1:0]               rdata
);

    localparam int AW = $clog2(DATA_WORDS);

    logic [XLEN-1:0] mem [DATA_WORDS];
    logic            clr_busy_reg;
    logic [AW-1:0]   clr_cnt_reg;

    assign clr.busy   = clr_busy_reg;
    assign clr.rf_idx = clr_cnt_reg[RIDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == AW'(DATA_WORDS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

/* design/tre_apb.sv */
// APB register block holding the program length.
`timescale 1ns / 1ps
module tre_apb
    import tre_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [LEN_W-1:0] program_length
);

    logic [LEN_W-1:0] len_reg;
    logic             wr_en;

    assign pready         = 1'b1;
    assign program_length = len_reg;
    assign wr_en          = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (wr_en && (paddr[2] == REG_PROGRAM_LENGTH))
        begin
            len_reg <= pwdata[LEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_PROGRAM_LENGTH)
        begin
            prdata = {{(32 - LEN_W){1'b0}}, len_reg};
        end
    end

endmodule

/* design/tiny_risc_instruction_executor.sv */
// Top level: three-stage executor around the register file and data memory.
`timescale 1ns / 1ps
// Takes one instruction word per transfer, fetched by the user at the PC the previous
// result reported (next_pc), and returns one result per instruction. Throughput is one
// instruction per cycle while the output is not stalled. The transfer loads the
// instruction into stage 1 and does the synchronous register file read; stage 1 then
// executes and does the data memory access as it moves into stage 2, and stage 2 writes
// back into the output register. Register hazards are resolved by forwarding, so
// back-to-back dependent instructions do not stall. After reset the data memory and
// register file are cleared, during which in_ch.ready stays low; program_length can be
// written meanwhile.
module tiny_risc_instruction_executor
    import tre_pkg::*;
#(
    parameter int DATA_WORDS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    tre_stream_if.sink          in_ch,
    tre_stream_if.source        out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int              AW   = $clog2(DATA_WORDS);
    localparam logic [XLEN-1:0] DW32 = XLEN'(DATA_WORDS);

    logic [LEN_W-1:0] program_length;
    tre_clr_t         clr;

    // pipeline control
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic adv1, adv2, accept;

    logic [IW_W-1:0] s1_instr_reg;
    logic [PC_W-1:0] pc_reg;

    // most recent register write, covers the read-during-write window
    logic              lw_valid_reg;
    logic [RIDX_W-1:0] lw_num_reg;
    logic [XLEN-1:0]   lw_val_reg;

    // stage 2 contents
    logic [PC_W-1:0]    s2_pc_reg;
    logic               s2_halt_reg;
    logic               s2_wr_reg;
    logic [RIDX_W-1:0]  s2_wnum_reg;
    logic [XLEN-1:0]    s2_wval_reg;
    logic               s2_ld_reg;
    logic               s2_st_reg;
    logic [SADDR_W-1:0] s2_saddr_reg;
    logic [XLEN-1:0]    s2_sval_reg;
    logic               s2_bad_reg;
    logic [XLEN-1:0]    s2_wval;

    tre_out_t out_data_reg;

    logic [XLEN-1:0] rf_rdata_a, rf_rdata_b, dm_rdata;

    // stage 1 decode and execute
    opcode_t           op;
    logic [RIDX_W-1:0] rs, rt, rd;
    funct_t            fn;
    logic [IMM_W-1:0]  imm;
    logic [XLEN-1:0]   a_val, b_val, ea;
    logic              run, ea_ok;
    logic [PC_W-1:0]   pc_inc;

    logic [PC_W-1:0]    n_pc;
    logic               n_wr, n_ld, n_st, n_bad;
    logic [RIDX_W-1:0]  n_wnum;
    logic [XLEN-1:0]    n_wval, n_sval;
    logic [SADDR_W-1:0] n_saddr;
    logic               dm_re, dm_we;

    tre_apb u_apb (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .program_length (program_length)
    );

    // handshake
    assign adv2         = s2_valid_reg && (!out_valid_reg || out_ch.ready);
    assign adv1         = s1_valid_reg && (!s2_valid_reg || adv2);
    assign in_ch.ready  = (!s1_valid_reg || adv1) && !clr.busy;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    tre_regfile u_regfile (
        .clk     (clk),
        .clr     (clr),
        .re      (accept),
        .raddr_a (in_ch.data.instruction_word[11:9]),
        .raddr_b (in_ch.data.instruction_word[8:6]),
        .rdata_a (rf_rdata_a),
        .rdata_b (rf_rdata_b),
        .we      (adv2 && s2_wr_reg),
        .waddr   (s2_wnum_reg),
        .wdata   (s2_wval)
    );

    tre_dmem #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (clr),
        .re    (dm_re),
        .we    (dm_we),
        .addr  (ea[AW-1:0]),
        .wdata (b_val),
        .rdata (dm_rdata)
    );

    assign op  = s1_instr_reg[15:12];
    assign rs  = s1_instr_reg[11:9];
    assign rt  = s1_instr_reg[8:6];
    assign rd  = s1_instr_reg[5:3];
    assign fn  = s1_instr_reg[2:0];
    assign imm = s1_instr_reg[IMM_W-1:0];

    assign s2_wval = s2_ld_reg ? dm_rdata : s2_wval_reg;

    // operand forwarding: stage 2 first, then the last completed write
    always_comb
    begin
        if (s2_valid_reg && s2_wr_reg && (s2_wnum_reg == rs))
            a_val = s2_wval;
        else if (lw_valid_reg && (lw_num_reg == rs))
            a_val = lw_val_reg;
        else
            a_val = rf_rdata_a;

        if (s2_valid_reg && s2_wr_reg && (s2_wnum_reg == rt))
            b_val = s2_wval;
        else if (lw_valid_reg && (lw_num_reg == rt))
            b_val = lw_val_reg;
        else
            b_val = rf_rdata_b;
    end

    assign run    = {1'b0, pc_reg} < program_length;
    assign pc_inc = pc_reg + PC_W'(1);
    assign ea     = a_val + XLEN'(imm);
    assign ea_ok  = !ea[XLEN-1] && (ea < DW32);
    assign dm_re  = adv1 && run && (op == OP_LW) && ea_ok;
    assign dm_we  = adv1 && run && (op == OP_SW) && ea_ok;

    always_comb
    begin
        n_pc    = pc_inc;
        n_wr    = 1'b0;
        n_wnum  = '0;
        n_wval  = '0;
        n_ld    = 1'b0;
        n_st    = 1'b0;
        n_saddr = '0;
        n_sval  = '0;
        n_bad   = 1'b0;
        if (!run)
        begin
            n_pc = pc_reg;
        end
        else
        begin
            unique case (op)
                OP_RTYPE:
                begin
                    n_wr   = 1'b1;
                    n_wnum = rd;
                    n_wval = alu(a_val, b_val, fn);
                end
                OP_ADDI:
                begin
                    n_wr   = 1'b1;
                    n_wnum = rt;
                    n_wval = ea;
                end
                OP_LW:
                begin
                    n_wr   = 1'b1;
                    n_wnum = rt;
                    n_ld   = ea_ok;
                    n_bad  = !ea_ok;
                end
                OP_SW:
                begin
                    n_bad = !ea_ok;
                    if (ea_ok)
                    begin
                        n_st    = 1'b1;
                        n_saddr = ea[SADDR_W-1:0];
                        n_sval  = b_val;
                    end
                end
                OP_BEQ:
                begin
                    if (a_val == b_val)
                        n_pc = pc_inc + PC_W'(imm);
                end
                OP_JUMP:
                begin
                    n_pc = s1_instr_reg[PC_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            lw_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (adv1)
                s1_valid_reg <= 1'b0;

            if (adv1)
                s2_valid_reg <= 1'b1;
            else if (adv2)
                s2_valid_reg <= 1'b0;

            if (adv2)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            if (adv1)
                pc_reg <= n_pc;

            if (adv2 && s2_wr_reg)
                lw_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_instr_reg <= in_ch.data.instruction_word;

        if (adv1)
        begin
            s2_pc_reg    <= n_pc;
            s2_halt_reg  <= !run;
            s2_wr_reg    <= n_wr;
            s2_wnum_reg  <= n_wnum;
            s2_wval_reg  <= n_wval;
            s2_ld_reg    <= n_ld;
            s2_st_reg    <= n_st;
            s2_saddr_reg <= n_saddr;
            s2_sval_reg  <= n_sval;
            s2_bad_reg   <= n_bad;
        end

        if (adv2 && s2_wr_reg)
        begin
            lw_num_reg <= s2_wnum_reg;
            lw_val_reg <= s2_wval;
        end

        if (adv2)
        begin
            out_data_reg.next_pc       <= s2_pc_reg;
            out_data_reg.halted        <= s2_halt_reg;
            out_data_reg.reg_written   <= s2_wr_reg;
            out_data_reg.reg_number    <= s2_wnum_reg;
            out_data_reg.reg_value     <= s2_wval;
            out_data_reg.stored        <= s2_st_reg;
            out_data_reg.store_address <= s2_saddr_reg;
            out_data_reg.store_value   <= s2_sval_reg;
            out_data_reg.bad_address   <= s2_bad_reg;
        end
    end

endmodule

/* design/tre_checker.sv */
// Port-level assertions for the executor, bound to the top level.
`timescale 1ns / 1ps
module tre_checker
    import tre_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_ready,
    input tre_out_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // a halted step touches no state
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.halted |->
            !out_data.reg_written && !out_data.stored && !out_data.bad_address)
        else $error("halted step reports a state change");

    // a step writes a register or memory, never both; a dropped store stores nothing
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.stored |-> !out_data.reg_written && !out_data.bad_address)
        else $error("store reported together with register write or bad address");

    // unused write fields read as zero
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.reg_written |->
            out_data.reg_number == '0 && out_data.reg_value == '0)
        else $error("register fields set without a register write");

endmodule

bind tiny_risc_instruction_executor tre_checker u_tre_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
